// File: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, codes and the command type of the text console engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // default geometry and queue depth
  localparam int DEF_ROWS        = 25;
  localparam int DEF_COLUMNS     = 80;
  localparam int DEF_QUEUE_DEPTH = 2;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // colour reset values and the blank cell written by the reset sweep
  localparam logic [3:0]  FG_RESET    = 4'hF;
  localparam logic [3:0]  BG_RESET    = 4'h0;
  localparam logic [15:0] BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  // configuration register indexes
  localparam logic [7:0] REG_FG = 8'd0;
  localparam logic [7:0] REG_BG = 8'd1;

  // input mode codes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_BACK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // classified operation codes
  localparam logic [2:0] OP_PUT       = 3'd0;
  localparam logic [2:0] OP_NEWLINE   = 3'd1;
  localparam logic [2:0] OP_BACKSPACE = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_READ_NONE = 3'd5;

  // command passed from the front end to the executor
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

endpackage

// File: rtl/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channels of the text console engine: items, results, config.
// ----------------------------------------------------------------------------
interface tcc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

interface tcc_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic [7:0] cell_char;
  logic [7:0] cell_attribute;
  logic       scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_attribute,
                  scrolled, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attribute,
                  scrolled, output ready);
endinterface

interface tcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console engine: cell store, cursor, scrolling, clear and cell read.
// ----------------------------------------------------------------------------
// latency to a result: put, newline without scroll and off-screen read pass
// the queue and the result register; backspace and read add the write or
// read-wait state; a line scroll first blanks the bottom row, a clear every
// cell, one cell per cycle; throughput: one simple item per cycle while
// results are taken, bound by the single store write port; reset: the store
// is swept to blanks while no item is taken; configuration writes are accepted throughout
module text_console_cursor_scroll_unit #(
  parameter int ROWS        = tcc_pkg::DEF_ROWS,
  parameter int COLUMNS     = tcc_pkg::DEF_COLUMNS,
  parameter int QUEUE_DEPTH = tcc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  tcc_item_if.sink     item_in,
  tcc_result_if.source result_out,
  tcc_cfg_if.sink      cfg
);

  localparam int CMD_W = $bits(tcc_pkg::cmd_t);

  logic               push_valid;
  logic               push_ready;
  tcc_pkg::cmd_t      push_cmd;
  logic               pop_valid;
  logic               pop_ready;
  logic [CMD_W-1:0]   pop_bits;
  tcc_pkg::cmd_t      pop_cmd;
  logic               init_busy;

  // front end
  tcc_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .item_in    (item_in),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // command queue
  tcc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  assign pop_cmd = tcc_pkg::cmd_t'(pop_bits);

  // executor
  tcc_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .result_out (result_out),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd        (pop_cmd),
    .init_busy  (init_busy)
  );

endmodule

// File: rtl/tcc_ram.sv
// ----------------------------------------------------------------------------
// tcc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcc_fifo.sv
// ----------------------------------------------------------------------------
// tcc_fifo
// Short command queue between the front end and the executor.
// ----------------------------------------------------------------------------
module tcc_fifo #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Front end: takes items and classifies them into executor commands.
// ----------------------------------------------------------------------------
module tcc_front #(
  parameter int ROWS    = tcc_pkg::DEF_ROWS,
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS
) (
  tcc_item_if.sink        item_in,
  input  logic            init_busy,
  output logic            push_valid,
  input  logic            push_ready,
  output tcc_pkg::cmd_t   push_cmd
);

  logic in_range;

  // read target inside the screen
  assign in_range = (32'(item_in.read_row) < ROWS) && (32'(item_in.read_col) < COLUMNS);

  // no item is taken while the store is being swept after reset
  assign item_in.ready = push_ready && !init_busy;
  assign push_valid    = item_in.valid && !init_busy;

  // classify the item
  always_comb begin
    push_cmd.ch       = item_in.char_code;
    push_cmd.read_row = item_in.read_row;
    push_cmd.read_col = item_in.read_col;
    case (item_in.mode)
      tcc_pkg::MODE_PUT: begin
        push_cmd.op = (item_in.char_code == tcc_pkg::CH_NEWLINE) ?
                      tcc_pkg::OP_NEWLINE : tcc_pkg::OP_PUT;
      end
      tcc_pkg::MODE_BACK:  push_cmd.op = tcc_pkg::OP_BACKSPACE;
      tcc_pkg::MODE_CLEAR: push_cmd.op = tcc_pkg::OP_CLEAR;
      tcc_pkg::MODE_READ: begin
        push_cmd.op = in_range ? tcc_pkg::OP_READ : tcc_pkg::OP_READ_NONE;
      end
      default: push_cmd.op = tcc_pkg::OP_READ_NONE;
    endcase
  end

endmodule

// File: rtl/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Executor: cursor, scroll offset, cell store sweeps and the result register.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int ROWS    = tcc_pkg::DEF_ROWS,
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS
) (
  input  logic            clk,
  input  logic            rst,
  tcc_cfg_if.sink         cfg,
  tcc_result_if.source    result_out,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  tcc_pkg::cmd_t   cmd,
  output logic            init_busy
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(CELLS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_FILL      = 3'd1;
  localparam logic [2:0] ST_BACK_WR   = 3'd2;
  localparam logic [2:0] ST_READ_WAIT = 3'd3;

  // physical store address of a screen row and column, rows rotate by top
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c,
                                               input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return AW'(s[RW-1:0]) * AW'(COLUMNS) + AW'(c);
  endfunction

  logic [2:0]    state, state_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] top, top_next;
  logic [AW-1:0] fill_addr, fill_addr_next;
  logic [AW-1:0] fill_cnt, fill_cnt_next;
  logic [15:0]   fill_data, fill_data_next;
  logic          fill_reply, fill_reply_next;
  logic          fill_scr, fill_scr_next;
  logic [3:0]    fg, bg;
  logic          res_valid, res_valid_next;
  logic [4:0]    res_row;
  logic [6:0]    res_col;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;
  logic          res_scr;

  logic          load_res;
  logic [7:0]    load_char;
  logic [7:0]    load_attr;
  logic          load_scr;
  logic          res_free;
  logic          cmd_fire;
  logic [7:0]    attr;
  logic [15:0]   blank;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_target;
  logic [AW-1:0] top_base;
  logic [RW+4:0] rd_row_ext;
  logic [CW+6:0] rd_col_ext;
  logic [RW+4:0] row_out_ext;
  logic [CW+6:0] col_out_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // colour registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcc_pkg::FG_RESET;
      bg <= tcc_pkg::BG_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == tcc_pkg::REG_FG) begin
        fg <= cfg.data[3:0];
      end else if (cfg.index == tcc_pkg::REG_BG) begin
        bg <= cfg.data[3:0];
      end
    end
  end

  assign attr  = {bg, fg};
  assign blank = {attr, tcc_pkg::CH_SPACE};

  // addresses
  assign rd_row_ext = (RW+5)'(cmd.read_row);
  assign rd_col_ext = (CW+7)'(cmd.read_col);
  assign cur_addr   = cell_addr(cur_row, cur_col, top);
  assign rd_target  = cell_addr(rd_row_ext[RW-1:0], rd_col_ext[CW-1:0], top);
  assign top_base   = AW'(top) * AW'(COLUMNS);

  // handshake with the queue and the result register
  assign res_free  = !res_valid || result_out.ready;
  assign cmd_ready = (state == ST_IDLE) && res_free;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign init_busy = (state == ST_FILL) && !fill_reply;

  // sequencer
  always_comb begin
    state_next      = state;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    top_next        = top;
    fill_addr_next  = fill_addr;
    fill_cnt_next   = fill_cnt;
    fill_data_next  = fill_data;
    fill_reply_next = fill_reply;
    fill_scr_next   = fill_scr;
    load_res        = 1'b0;
    load_char       = 8'd0;
    load_attr       = 8'd0;
    load_scr        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cur_addr;
    ram_wdata       = blank;
    ram_raddr       = rd_target;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd.op)
            tcc_pkg::OP_PUT, tcc_pkg::OP_NEWLINE: begin
              if (cmd.op == tcc_pkg::OP_PUT) begin
                ram_we    = 1'b1;
                ram_wdata = {attr, cmd.ch};
              end
              if (cmd.op == tcc_pkg::OP_PUT && cur_col != COL_LAST) begin
                cur_col_next = cur_col + 1'b1;
                load_res     = 1'b1;
              end else begin
                // next line, rotating the store on the last row
                cur_col_next = '0;
                if (cur_row == ROW_LAST) begin
                  top_next        = (top == ROW_LAST) ? '0 : top + 1'b1;
                  fill_addr_next  = top_base;
                  fill_cnt_next   = ROW_SPAN;
                  fill_data_next  = blank;
                  fill_reply_next = 1'b1;
                  fill_scr_next   = 1'b1;
                  state_next      = ST_FILL;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                  load_res     = 1'b1;
                end
              end
            end
            tcc_pkg::OP_BACKSPACE: begin
              if (cur_col != '0) begin
                cur_col_next = cur_col - 1'b1;
              end else if (cur_row != '0) begin
                cur_row_next = cur_row - 1'b1;
                cur_col_next = COL_LAST;
              end
              state_next = ST_BACK_WR;
            end
            tcc_pkg::OP_CLEAR: begin
              cur_row_next    = '0;
              cur_col_next    = '0;
              top_next        = '0;
              fill_addr_next  = '0;
              fill_cnt_next   = CELL_LAST;
              fill_data_next  = blank;
              fill_reply_next = 1'b1;
              fill_scr_next   = 1'b0;
              state_next      = ST_FILL;
            end
            tcc_pkg::OP_READ: begin
              state_next = ST_READ_WAIT;
            end
            default: begin
              load_res = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we         = 1'b1;
        ram_waddr      = fill_addr;
        ram_wdata      = fill_data;
        fill_addr_next = fill_addr + 1'b1;
        if (fill_cnt == '0) begin
          state_next = ST_IDLE;
          load_res   = fill_reply;
          load_scr   = fill_scr;
        end else begin
          fill_cnt_next = fill_cnt - 1'b1;
        end
      end
      ST_BACK_WR: begin
        ram_we     = 1'b1;
        load_res   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ_WAIT: begin
        load_res   = 1'b1;
        load_char  = ram_rdata[7:0];
        load_attr  = ram_rdata[15:8];
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    res_valid_next = res_valid && !result_out.ready;
    if (load_res) begin
      res_valid_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      cur_row    <= '0;
      cur_col    <= '0;
      top        <= '0;
      fill_addr  <= '0;
      fill_cnt   <= CELL_LAST;
      fill_data  <= tcc_pkg::BLANK_RESET;
      fill_reply <= 1'b0;
      fill_scr   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      top        <= top_next;
      fill_addr  <= fill_addr_next;
      fill_cnt   <= fill_cnt_next;
      fill_data  <= fill_data_next;
      fill_reply <= fill_reply_next;
      fill_scr   <= fill_scr_next;
      res_valid  <= res_valid_next;
    end
  end

  // result payload
  assign row_out_ext = (RW+5)'(cur_row_next);
  assign col_out_ext = (CW+7)'(cur_col_next);
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_row  <= row_out_ext[4:0];
      res_col  <= col_out_ext[6:0];
      res_char <= load_char;
      res_attr <= load_attr;
      res_scr  <= load_scr;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.cursor_row     = res_row;
  assign result_out.cursor_col     = res_col;
  assign result_out.cell_char      = res_char;
  assign result_out.cell_attribute = res_attr;
  assign result_out.scrolled       = res_scr;

  // a read issued from idle enters the read-wait state in the following cycle
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.op == tcc_pkg::OP_READ) |=> (state == ST_READ_WAIT))
    else $error("read did not enter the wait state");

  // the store is never written while a read is in flight
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ_WAIT) |-> !ram_we)
    else $error("store written during read wait");

  // a sweep ends after its last cell
  a_fill_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && fill_cnt == '0) |=> (state == ST_IDLE))
    else $error("sweep did not finish");

  // no command is taken from the queue during the reset sweep
  a_init_no_cmd: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !cmd_fire)
    else $error("command taken during reset sweep");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row <= ROW_LAST) && (cur_col <= COL_LAST))
    else $error("cursor off screen");

endmodule

// File: bench/console_checker.sv
// ----------------------------------------------------------------------------
// console_checker
// Watches the item, result and config channels of the text console engine,
// keeps its own copy of the screen, cursor and colours, and compares every
// result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module console_checker #(
  parameter int ROWS    = tcc_pkg::DEF_ROWS,
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS
) (
  input  logic  clk,
  input  logic  rst,
  tcc_item_if   items,
  tcc_result_if results,
  tcc_cfg_if    cfgs,
  output int    mismatches,
  output int    outstanding,
  output int    scrolls
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       scrolled;
  } console_result_t;

  // predicted screen state
  logic [15:0] screen [ROWS][COLUMNS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_colour;
  logic [3:0]  bg_colour;

  console_result_t pending_results [$];
  console_result_t got;
  console_result_t want;

  function automatic logic [15:0] blank_word();
    return {bg_colour, fg_colour, CH_SPACE};
  endfunction

  function automatic void fill_screen();
    logic [15:0] b;
    b = blank_word();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        screen[r][c] = b;
  endfunction

  // cursor to the start of the next row, scrolling from the last row
  function automatic logic advance_line();
    logic [15:0] b;
    b = blank_word();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen[r][c] = screen[r + 1][c];
      for (int c = 0; c < COLUMNS; c++)
        screen[ROWS - 1][c] = b;
      cur_row = ROWS - 1;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  // apply one item to the screen copy and return the result it should give
  function automatic console_result_t apply_console_op(input logic [1:0] mode,
                                                       input logic [7:0] ch,
                                                       input logic [4:0] rr,
                                                       input logic [6:0] rc);
    console_result_t r;
    logic [15:0] cell_word;
    r = '0;
    case (mode)
      MODE_PUT: begin
        if (ch == CH_NEWLINE) begin
          r.scrolled = advance_line();
        end else begin
          screen[cur_row][cur_col] = {bg_colour, fg_colour, ch};
          cur_col++;
          if (cur_col >= COLUMNS) r.scrolled = advance_line();
        end
      end
      MODE_BACK: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLUMNS - 1;
        end
        screen[cur_row][cur_col] = blank_word();
      end
      MODE_CLEAR: begin
        fill_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        // off-screen reads give an all-zero cell
        if (rr < ROWS && rc < COLUMNS) begin
          cell_word = screen[rr][rc];
          r.ch      = cell_word[7:0];
          r.attr    = cell_word[15:8];
        end
      end
    endcase
    r.row = cur_row[4:0];
    r.col = cur_col[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // transactions are taken at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      fg_colour = FG_RESET;
      bg_colour = BG_RESET;
      fill_screen();
      cur_row = 0;
      cur_col = 0;
      pending_results.delete();
    end else begin
      // compare result with the oldest prediction
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        got = '{results.cursor_row, results.cursor_col, results.cell_char,
                results.cell_attribute, results.scrolled};
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with none outstanding", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.row !== want.row) report_mismatch("cursor_row", got.row, want.row);
          if (got.col !== want.col) report_mismatch("cursor_col", got.col, want.col);
          if (got.ch !== want.ch) report_mismatch("cell_char", got.ch, want.ch);
          if (got.attr !== want.attr)
            report_mismatch("cell_attribute", got.attr, want.attr);
          if (got.scrolled !== want.scrolled)
            report_mismatch("scrolled", got.scrolled, want.scrolled);
        end
      end
      // colour register writes, unknown indexes ignored
      if (cfgs.valid === 1'b1 && cfgs.ready === 1'b1) begin
        case (cfgs.index)
          REG_FG:  fg_colour = cfgs.data[3:0];
          REG_BG:  bg_colour = cfgs.data[3:0];
          default: ;
        endcase
      end
      // predict for each accepted item
      if (items.valid === 1'b1 && items.ready === 1'b1) begin
        want = apply_console_op(items.mode, items.char_code, items.read_row, items.read_col);
        if (want.scrolled) scrolls++;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the text console engine: a directed pass over the special
// cases, then random bursts of text, newlines, backspaces, reads and clears
// under several colour settings and idling patterns; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int ROWS         = DEF_ROWS;
  localparam int COLUMNS      = DEF_COLUMNS;
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 6;
  localparam int RANDOM_ITEMS = 850;

  logic clk;
  logic rst;

  tcc_item_if   items();
  tcc_result_if results();
  tcc_cfg_if    cfgs();

  int mismatches;
  int outstanding;
  int scrolls;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;
  int holds_done;
  int item_count;
  int cfg_writes;
  int cycles;
  int mode_count [4];

  text_console_cursor_scroll_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (items),
    .result_out (results),
    .cfg        (cfgs)
  );

  console_checker #(.ROWS(ROWS), .COLUMNS(COLUMNS)) console_chk (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .cfgs        (cfgs),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .scrolls     (scrolls)
  );

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding", outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        results.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one item; valid stays high on return so items can go back to back
  task automatic send_item(input logic [1:0] m, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid     <= 1'b1;
    items.mode      <= m;
    items.char_code <= ch;
    items.read_row  <= rr;
    items.read_col  <= rc;
    do @(posedge clk); while (items.ready !== 1'b1);
    item_count++;
    mode_count[m]++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfgs.valid <= 1'b1;
    cfgs.index <= idx;
    cfgs.data  <= val;
    do @(posedge clk); while (cfgs.ready !== 1'b1);
    cfg_writes++;
    @(negedge clk);
    cfgs.valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic drain();
    items.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one random burst of console traffic
  task automatic random_burst();
    int kind;
    int len;
    int row;
    int col;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // a run of text, ended by a newline half the time
      len = $urandom_range(1, 40);
      repeat (len) send_item(MODE_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
      if ($urandom_range(1) == 1)
        send_item(MODE_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
    end else if (kind < 47) begin
      // newline run, at times enough to reach the bottom and scroll
      len = $urandom_range(1, 30);
      repeat (len) send_item(MODE_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
    end else if (kind < 57) begin
      // backspaces, now and then across one or two line starts
      len = ($urandom_range(3) == 0) ? $urandom_range(1, COLUMNS + 5) : $urandom_range(1, 8);
      repeat (len) send_item(MODE_BACK, 8'($urandom), 5'($urandom), 7'($urandom));
    end else if (kind < 90) begin
      // read back a stretch of one row, sometimes off the screen
      len = $urandom_range(1, 16);
      row = $urandom_range(ROWS - 1);
      col = $urandom_range(COLUMNS - 1);
      repeat (len) begin
        if ($urandom_range(7) == 0)
          send_item(MODE_READ, 8'($urandom), 5'($urandom), 7'($urandom));
        else
          send_item(MODE_READ, 8'($urandom), 5'(row), 7'(col));
        col = (col + 1) % COLUMNS;
      end
    end else if (kind < 93) begin
      send_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end else begin
      // noise: every field random
      len = $urandom_range(1, 4);
      repeat (len) send_item(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    int seg;
    int base;
    logic [3:0] fg;
    logic [3:0] bg;

    rst             = 1'b1;
    items.valid     = 1'b0;
    items.mode      = MODE_PUT;
    items.char_code = '0;
    items.read_row  = '0;
    items.read_col  = '0;
    results.ready   = 1'b0;
    cfgs.valid      = 1'b0;
    cfgs.index      = '0;
    cfgs.data       = '0;
    send_idle_pct   = 8;
    recv_idle_pct   = 88;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset colours, edges of the cursor and of the read fields
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'd0);
    send_item(MODE_READ, 8'($urandom), 5'(ROWS - 1), 7'(COLUMNS - 1));
    // backspace at home blanks the cell in place
    send_item(MODE_BACK, 8'($urandom), 5'($urandom), 7'($urandom));
    send_item(MODE_PUT, 8'h00, 5'($urandom), 7'($urandom));
    send_item(MODE_PUT, 8'hFF, 5'($urandom), 7'($urandom));
    send_item(MODE_PUT, 8'h41, 5'($urandom), 7'($urandom));
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'd0);
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'd1);
    send_item(MODE_BACK, 8'($urandom), 5'($urandom), 7'($urandom));
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'd2);
    // newline then backspace across the line start
    send_item(MODE_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
    send_item(MODE_BACK, 8'($urandom), 5'($urandom), 7'($urandom));
    // put in the last column wraps to the next row
    send_item(MODE_PUT, 8'h5A, 5'($urandom), 7'($urandom));
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'(COLUMNS - 1));
    // reads outside the screen
    send_item(MODE_READ, 8'($urandom), 5'(ROWS), 7'd0);
    send_item(MODE_READ, 8'($urandom), 5'h1F, 7'h7F);
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'(COLUMNS));
    send_item(MODE_READ, 8'($urandom), 5'd0, 7'h7F);
    // clear, then home-position cases again
    send_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    send_item(MODE_READ, 8'($urandom), 5'd1, 7'd0);
    send_item(MODE_BACK, 8'($urandom), 5'($urandom), 7'($urandom));
    send_item(MODE_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
    base = item_count;

    // random part in segments, each with its colours and one of three idling patterns
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      send_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 88 : 0;
      recv_idle_pct = (seg < 2) ? 88 : (seg < 4) ? 8 : 0;
      case (seg)
        0: begin
          fg = 4'h0;
          bg = 4'h0;
        end
        1: begin
          fg = 4'hF;
          bg = 4'hF;
        end
        3: begin
          fg = 4'hF;
          bg = 4'h0;
        end
        4: begin
          fg = 4'h0;
          bg = 4'hF;
        end
        default: begin
          fg = 4'($urandom);
          bg = 4'($urandom);
        end
      endcase
      // upper data bits are dropped; an unknown index changes nothing
      write_reg(REG_FG, {4'($urandom), fg});
      write_reg(REG_BG, {4'($urandom), bg});
      write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      // long result hold-off while items keep coming
      if (seg == 1 || seg == 4) hold_asks++;
      while (item_count < base + (seg + 1) * RANDOM_ITEMS / SEGMENTS) random_burst();
    end

    drain();
    repeat (100) @(negedge clk);

    $display("%0d item transactions (%0d put, %0d backspace, %0d clear, %0d read), %0d writes",
             item_count, mode_count[MODE_PUT], mode_count[MODE_BACK],
             mode_count[MODE_CLEAR], mode_count[MODE_READ], cfg_writes);
    $display("six colour settings, three idling patterns, two long hold-offs, %0d scrolls",
             scrolls);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
